### hdl/bclp_pkg.sv
`default_nettype none

package bclp_pkg;

	// panel size
	localparam int NUM_STATUS_LEDS = 4;
	localparam int NUM_BARS        = 2;
	localparam int BAR_STEPS       = 6;

	// field and state widths
	localparam int KIND_W   = 3;
	localparam int TARGET_W = 2;
	localparam int VALUE_W  = 16;
	localparam int SCAN_W   = 8;
	localparam int TIME_W   = 32;
	localparam int PERIOD_W = 16;
	localparam int POS_W    = 3;
	localparam int PIN_W    = 3;
	localparam int LEDS_W   = 4;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SET_LED   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LED_BLINK = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BAR_LEVEL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BAR_BLINK = 3'd4;

	localparam logic [SCAN_W-1:0] SCAN_INTERVAL_RST = 8'd2;

	typedef logic [TIME_W-1:0]   ms_t;
	typedef logic [PERIOD_W-1:0] period_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [PIN_W-1:0]    pins_t;

	typedef struct packed {
		pins_t drive;
		pins_t level;
	} bar_pins_t;

	localparam bar_pins_t BAR_PINS_RST = '{drive: 3'd7, level: 3'd0};

	// scan position to three-pin charlieplex picture
	function automatic bar_pins_t pos_to_pins(pos_t p);
		bar_pins_t r;
		case (p)
			3'd1:    r = '{drive: 3'd5, level: 3'd4};
			3'd2:    r = '{drive: 3'd5, level: 3'd1};
			3'd3:    r = '{drive: 3'd6, level: 3'd4};
			3'd4:    r = '{drive: 3'd6, level: 3'd2};
			3'd5:    r = '{drive: 3'd3, level: 3'd2};
			3'd6:    r = '{drive: 3'd3, level: 3'd1};
			default: r = '{drive: 3'd7, level: 3'd0};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/blinking_charlieplex_led_panel_unit.sv
// Panel LED driver for four status LEDs and two three-pin charlieplexed bar
// graphs. Each input transfer is a millisecond tick (kind 0) or a write of an
// LED on flag, an LED blink period, a bar level or a bar blink period, and
// each one yields exactly one output transfer carrying the current pin
// picture; scanned is set when that tick ran a scan update. A tick scans
// once more than scan_interval_ms (cfg port, reset 2) milliseconds have
// passed since the last scan; all time checks are wrap-safe 32-bit
// differences. One transfer per clock unless out_ready stalls; an item
// passes the input register, then the state and result registers, which
// one pass of update logic writes together. The output register holds a
// finished result while the next item waits in the input register.
// Configuration writes are always accepted (cfg_ready is tied high) and
// should only be issued while no transfer is in flight.
`default_nettype none

module blinking_charlieplex_led_panel_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bclp_pkg::SCAN_W-1:0]   cfg_data,
	// input items
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [bclp_pkg::KIND_W-1:0]   kind,
	input  wire logic [bclp_pkg::TARGET_W-1:0] target,
	input  wire logic [bclp_pkg::VALUE_W-1:0]  value,
	// results
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [bclp_pkg::LEDS_W-1:0]        status_leds,
	output logic [bclp_pkg::PIN_W-1:0]         left_pin_drive,
	output logic [bclp_pkg::PIN_W-1:0]         left_pin_level,
	output logic [bclp_pkg::PIN_W-1:0]         right_pin_drive,
	output logic [bclp_pkg::PIN_W-1:0]         right_pin_level,
	output logic                               scanned
);

	import bclp_pkg::*;

	// input register
	logic                valid_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [TARGET_W-1:0] target_s1;
	logic [VALUE_W-1:0]  value_s1;

	logic out_valid_q;
	logic advance;

	// state
	logic [SCAN_W-1:0] scan_ivl_q;
	ms_t               ms_now_q, ms_now_d;
	ms_t               ms_next_q, ms_next_d;   // always ms_now_q + 1
	ms_t               last_scan_q, last_scan_d;

	logic    led_on_q     [NUM_STATUS_LEDS];
	logic    led_on_d     [NUM_STATUS_LEDS];
	logic    led_phase_q  [NUM_STATUS_LEDS];
	logic    led_phase_d  [NUM_STATUS_LEDS];
	period_t led_period_q [NUM_STATUS_LEDS];
	period_t led_period_d [NUM_STATUS_LEDS];
	ms_t     led_last_q   [NUM_STATUS_LEDS];
	ms_t     led_last_d   [NUM_STATUS_LEDS];

	pos_t    bar_level_q  [NUM_BARS];
	pos_t    bar_level_d  [NUM_BARS];
	pos_t    bar_pos_q    [NUM_BARS];
	pos_t    bar_pos_d    [NUM_BARS];
	logic    bar_phase_q  [NUM_BARS];
	logic    bar_phase_d  [NUM_BARS];
	period_t bar_period_q [NUM_BARS];
	period_t bar_period_d [NUM_BARS];
	ms_t     bar_last_q   [NUM_BARS];
	ms_t     bar_last_d   [NUM_BARS];

	// held pin picture, which is also the result register
	logic [LEDS_W-1:0] status_q, status_d;
	bar_pins_t         left_q, left_d;
	bar_pins_t         right_q, right_d;
	logic              scanned_q, scanned_d;

	// handshakes: the input register moves on when the result slot is free
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1   <= kind;
			target_s1 <= target;
			value_s1  <= value;
		end
	end

	// one update pass per item
	always_comb begin
		logic  scan_due;
		logic  ph;
		pos_t  p;
		pos_t  p_inc;
		pos_t  lv;

		ph          = 1'b0;
		p           = '0;
		p_inc       = '0;
		ms_now_d    = ms_now_q;
		ms_next_d   = ms_next_q;
		last_scan_d = last_scan_q;
		status_d    = status_q;
		left_d      = left_q;
		right_d     = right_q;
		scanned_d   = 1'b0;
		for (int i = 0; i < NUM_STATUS_LEDS; i++) begin
			led_on_d[i]     = led_on_q[i];
			led_phase_d[i]  = led_phase_q[i];
			led_period_d[i] = led_period_q[i];
			led_last_d[i]   = led_last_q[i];
		end
		for (int i = 0; i < NUM_BARS; i++) begin
			bar_level_d[i]  = bar_level_q[i];
			bar_pos_d[i]    = bar_pos_q[i];
			bar_phase_d[i]  = bar_phase_q[i];
			bar_period_d[i] = bar_period_q[i];
			bar_last_d[i]   = bar_last_q[i];
		end

		scan_due = (ms_next_q - last_scan_q) > ms_t'(scan_ivl_q);
		lv = (value_s1 > VALUE_W'(BAR_STEPS)) ? pos_t'(BAR_STEPS) : value_s1[POS_W-1:0];

		unique case (kind_s1)
			KIND_TICK: begin
				ms_now_d  = ms_next_q;
				ms_next_d = ms_next_q + ms_t'(1);
				if (scan_due) begin
					last_scan_d = ms_next_q;
					scanned_d   = 1'b1;
				end
			end
			KIND_SET_LED: begin
				for (int i = 0; i < NUM_STATUS_LEDS; i++) begin
					if (int'(target_s1) == i) begin
						led_last_d[i]   = ms_now_q;
						led_period_d[i] = '0;
						led_on_d[i]     = (value_s1 != '0);
					end
				end
			end
			KIND_LED_BLINK: begin
				for (int i = 0; i < NUM_STATUS_LEDS; i++) begin
					if (int'(target_s1) == i) begin
						led_last_d[i]   = ms_now_q;
						led_period_d[i] = value_s1;
					end
				end
			end
			KIND_BAR_LEVEL: begin
				for (int i = 0; i < NUM_BARS; i++) begin
					if (int'(target_s1) == i && lv != bar_level_q[i]) begin
						bar_level_d[i] = lv;
						bar_pos_d[i]   = pos_t'(1);
					end
				end
			end
			KIND_BAR_BLINK: begin
				for (int i = 0; i < NUM_BARS; i++) begin
					if (int'(target_s1) == i) begin
						bar_last_d[i]   = ms_now_q;
						bar_period_d[i] = value_s1;
					end
				end
			end
			default: begin
			end
		endcase

		// scan: only on a tick, which leaves the channel state untouched above
		if (scanned_d) begin
			status_d = '0;
			for (int i = 0; i < NUM_STATUS_LEDS; i++) begin
				ph = led_phase_q[i];
				if (led_period_q[i] == '0) begin
					ph = 1'b1;
				end else if ((ms_next_q - led_last_q[i]) > ms_t'(led_period_q[i])) begin
					ph            = !ph;
					led_last_d[i] = ms_next_q;
				end
				led_phase_d[i] = ph;
				if (i < LEDS_W) begin
					status_d[i] = ph && led_on_q[i];
				end
			end
			for (int i = 0; i < NUM_BARS; i++) begin
				ph = bar_phase_q[i];
				if (bar_period_q[i] == '0) begin
					ph = 1'b1;
				end else if ((ms_next_q - bar_last_q[i]) > ms_t'(bar_period_q[i])) begin
					ph            = !ph;
					bar_last_d[i] = ms_next_q;
				end
				bar_phase_d[i] = ph;
				// off phase blanks the bar and restarts the sweep
				p = ph ? bar_pos_q[i] : '0;
				if (i == 0) begin
					left_d = pos_to_pins(p);
				end else if (i == 1) begin
					right_d = pos_to_pins(p);
				end
				p_inc = p + pos_t'(1);
				if (p_inc > bar_level_q[i]) begin
					p_inc = (bar_level_q[i] != '0) ? pos_t'(1) : '0;
				end
				bar_pos_d[i] = p_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ivl_q  <= SCAN_INTERVAL_RST;
			ms_now_q    <= '0;
			ms_next_q   <= ms_t'(1);
			last_scan_q <= '0;
			status_q    <= '0;
			left_q      <= BAR_PINS_RST;
			right_q     <= BAR_PINS_RST;
			scanned_q   <= 1'b0;
			for (int i = 0; i < NUM_STATUS_LEDS; i++) begin
				led_on_q[i]     <= 1'b0;
				led_phase_q[i]  <= 1'b0;
				led_period_q[i] <= '0;
				led_last_q[i]   <= '0;
			end
			for (int i = 0; i < NUM_BARS; i++) begin
				bar_level_q[i]  <= '0;
				bar_pos_q[i]    <= '0;
				bar_phase_q[i]  <= 1'b0;
				bar_period_q[i] <= '0;
				bar_last_q[i]   <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				scan_ivl_q <= cfg_data;
			end
			if (advance) begin
				ms_now_q    <= ms_now_d;
				ms_next_q   <= ms_next_d;
				last_scan_q <= last_scan_d;
				status_q    <= status_d;
				left_q      <= left_d;
				right_q     <= right_d;
				scanned_q   <= scanned_d;
				for (int i = 0; i < NUM_STATUS_LEDS; i++) begin
					led_on_q[i]     <= led_on_d[i];
					led_phase_q[i]  <= led_phase_d[i];
					led_period_q[i] <= led_period_d[i];
					led_last_q[i]   <= led_last_d[i];
				end
				for (int i = 0; i < NUM_BARS; i++) begin
					bar_level_q[i]  <= bar_level_d[i];
					bar_pos_q[i]    <= bar_pos_d[i];
					bar_phase_q[i]  <= bar_phase_d[i];
					bar_period_q[i] <= bar_period_d[i];
					bar_last_q[i]   <= bar_last_d[i];
				end
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status_leds     = status_q;
	assign left_pin_drive  = left_q.drive;
	assign left_pin_level  = left_q.level;
	assign right_pin_drive = right_q.drive;
	assign right_pin_level = right_q.level;
	assign scanned         = scanned_q;

endmodule

`default_nettype wire

### tb/blinking_charlieplex_led_panel_unit_tb.sv
module blinking_charlieplex_led_panel_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bclp_pkg::*;

	// Run guard: set well above what about 1800 items need.
	localparam int CYCLE_LIMIT = 400000;

	// Kinds 5..7 are not decoded by the block. They must leave all state alone.
	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

	// Scan position to pin picture. Position p sits at bits [3p +: 3].
	// Positions 0 and 7 drive all pins low.
	localparam logic [23:0] DRIVE_LUT =
		{3'd7, 3'd3, 3'd3, 3'd6, 3'd6, 3'd5, 3'd5, 3'd7};
	localparam logic [23:0] LEVEL_LUT =
		{3'd0, 3'd1, 3'd2, 3'd2, 3'd4, 3'd1, 3'd4, 3'd0};

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [TARGET_W-1:0] target;
		logic [VALUE_W-1:0]  value;
	} panel_cmd_t;

	typedef struct packed {
		logic [LEDS_W-1:0] leds;
		bar_pins_t         left;
		bar_pins_t         right;
		logic              scanned;
	} panel_view_t;

	// Clock, reset and block ports. Every input starts at a known value.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [SCAN_W-1:0]   cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [KIND_W-1:0]   kind      = '0;
	logic [TARGET_W-1:0] target    = '0;
	logic [VALUE_W-1:0]  value     = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [LEDS_W-1:0]   status_leds;
	logic [PIN_W-1:0]    left_pin_drive;
	logic [PIN_W-1:0]    left_pin_level;
	logic [PIN_W-1:0]    right_pin_drive;
	logic [PIN_W-1:0]    right_pin_level;
	logic                scanned;

	// Commands waiting for the driver, and pictures waiting for the block.
	panel_cmd_t  cmds_to_send [$];
	panel_view_t views_due [$];

	int mismatches  = 0;
	int cycle_count = 0;
	int idle_pct    = 0;	// chance, in percent, that a side idles before a transfer
	int send_idle   = 0;
	int recv_idle   = 0;

	// Predicted panel state.
	logic [SCAN_W-1:0]   scan_gap;
	ms_t                 now_ms;
	ms_t                 scan_ms_at;
	logic [NUM_STATUS_LEDS-1:0] led_on;
	logic [NUM_STATUS_LEDS-1:0] led_phase;
	period_t             led_period    [NUM_STATUS_LEDS];
	ms_t                 led_toggle_at [NUM_STATUS_LEDS];
	pos_t                bar_level     [NUM_BARS];
	pos_t                bar_pos       [NUM_BARS];
	logic [NUM_BARS-1:0] bar_phase;
	period_t             bar_period    [NUM_BARS];
	ms_t                 bar_toggle_at [NUM_BARS];
	// Held pin picture. It changes only on a scan.
	logic [LEDS_W-1:0]   lit_leds;
	bar_pins_t           bar_shown     [NUM_BARS];

	blinking_charlieplex_led_panel_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.target          (target),
		.value           (value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status_leds     (status_leds),
		.left_pin_drive  (left_pin_drive),
		.left_pin_level  (left_pin_level),
		.right_pin_drive (right_pin_drive),
		.right_pin_level (right_pin_level),
		.scanned         (scanned)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Panel predictor
	// ---------------------------------------------------------------------
	function automatic void panel_reset();
		int i;
		scan_gap   = SCAN_INTERVAL_RST;
		now_ms     = '0;
		scan_ms_at = '0;
		led_on     = '0;
		led_phase  = '0;
		bar_phase  = '0;
		lit_leds   = '0;
		for (i = 0; i < NUM_STATUS_LEDS; i++) begin
			led_period[i]    = '0;
			led_toggle_at[i] = '0;
		end
		for (i = 0; i < NUM_BARS; i++) begin
			bar_level[i]     = '0;
			bar_pos[i]       = '0;
			bar_period[i]    = '0;
			bar_toggle_at[i] = '0;
			bar_shown[i]     = BAR_PINS_RST;
		end
	endfunction

	// One scan pass. A channel with period 0 is steady and is forced on.
	// Otherwise its phase flips once the time since the last flip exceeds
	// the period. The subtraction wraps at 32 bits.
	function automatic void panel_scan();
		int i;
		lit_leds = '0;
		for (i = 0; i < NUM_STATUS_LEDS; i++) begin
			if (led_period[i] != '0) begin
				if (now_ms - led_toggle_at[i] > led_period[i]) begin
					led_toggle_at[i] = now_ms;
					led_phase[i]     = ~led_phase[i];
				end
			end else begin
				led_phase[i] = 1'b1;
			end
			if (led_phase[i] && led_on[i])
				lit_leds[i] = 1'b1;
		end
		for (i = 0; i < NUM_BARS; i++) begin
			if (bar_period[i] != '0) begin
				if (now_ms - bar_toggle_at[i] > bar_period[i]) begin
					bar_toggle_at[i] = now_ms;
					bar_phase[i]     = ~bar_phase[i];
				end
			end else begin
				bar_phase[i] = 1'b1;
			end
			// A bar in its off phase shows the blank position.
			if (!bar_phase[i])
				bar_pos[i] = '0;
			bar_shown[i] = '{drive: DRIVE_LUT[3*bar_pos[i] +: 3],
				level: LEVEL_LUT[3*bar_pos[i] +: 3]};
			// Step, and wrap to 1 past the level. A bar at level 0 falls to 0.
			bar_pos[i] = bar_pos[i] + 3'd1;
			if (bar_pos[i] > bar_level[i])
				bar_pos[i] = (bar_level[i] != '0) ? 3'd1 : 3'd0;
		end
	endfunction

	function automatic panel_view_t panel_step(panel_cmd_t c);
		panel_view_t v;
		v.scanned = 1'b0;
		case (c.kind)
			KIND_TICK: begin
				now_ms = now_ms + 1;
				if (now_ms - scan_ms_at > scan_gap) begin
					scan_ms_at = now_ms;
					panel_scan();
					v.scanned = 1'b1;
				end
			end
			KIND_SET_LED: begin
				if (c.target < NUM_STATUS_LEDS) begin
					led_toggle_at[c.target] = now_ms;
					led_period[c.target]    = '0;
					led_on[c.target]        = (c.value != '0);
				end
			end
			KIND_LED_BLINK: begin
				if (c.target < NUM_STATUS_LEDS) begin
					led_toggle_at[c.target] = now_ms;
					led_period[c.target]    = c.value;
				end
			end
			KIND_BAR_LEVEL: begin
				if (c.target < NUM_BARS) begin
					pos_t lv;
					lv = (c.value > BAR_STEPS) ? pos_t'(BAR_STEPS) : pos_t'(c.value);
					// A new level restarts the scan at position 1.
					if (lv != bar_level[c.target]) begin
						bar_level[c.target] = lv;
						bar_pos[c.target]   = 3'd1;
					end
				end
			end
			KIND_BAR_BLINK: begin
				if (c.target < NUM_BARS) begin
					bar_toggle_at[c.target] = now_ms;
					bar_period[c.target]    = c.value;
				end
			end
			default: ;
		endcase
		v.leds  = lit_leds;
		v.left  = bar_shown[0];
		v.right = bar_shown[1];
		return v;
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------
	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// One place samples every handshake: a result transfer is checked first,
	// then a register write and an input transfer go into the predictor.
	// Both sides see values from before the edge, so event order inside
	// the time step does not matter.
	always @(posedge clk) begin : score_side
		panel_view_t seen;
		panel_view_t want;
		panel_cmd_t  taken;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen = '{leds: status_leds,
					left: '{drive: left_pin_drive, level: left_pin_level},
					right: '{drive: right_pin_drive, level: right_pin_level},
					scanned: scanned};
				if (views_due.size() == 0) begin
					report_mismatch("result with nothing outstanding", int'(seen), 0);
				end else begin
					want = views_due.pop_front();
					if (seen.leds != want.leds)
						report_mismatch("status_leds", int'(seen.leds), int'(want.leds));
					if (seen.left.drive != want.left.drive)
						report_mismatch("left_pin_drive", int'(seen.left.drive),
							int'(want.left.drive));
					if (seen.left.level != want.left.level)
						report_mismatch("left_pin_level", int'(seen.left.level),
							int'(want.left.level));
					if (seen.right.drive != want.right.drive)
						report_mismatch("right_pin_drive", int'(seen.right.drive),
							int'(want.right.drive));
					if (seen.right.level != want.right.level)
						report_mismatch("right_pin_level", int'(seen.right.level),
							int'(want.right.level));
					if (seen.scanned != want.scanned)
						report_mismatch("scanned", int'(seen.scanned), int'(want.scanned));
				end
			end
			if (cfg_valid && cfg_ready)
				scan_gap = cfg_data;
			if (in_valid && in_ready) begin
				taken = '{kind: kind, target: target, value: value};
				views_due.push_back(panel_step(taken));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Driver, result side and run guard
	// ---------------------------------------------------------------------
	// Each side draws a random run of idle cycles per transfer. idle_pct is the share
	// of transfers that idle at all. At 0 the sides run back to back.
	function automatic int draw_wait();
		if ($urandom_range(0, 99) < idle_pct)
			return $urandom_range(1, 14);
		return 0;
	endfunction

	// Valid holds with a stable payload until the transfer. After a transfer
	// the next command follows at once, or after its drawn idle cycles.
	always @(posedge clk or negedge arst_n) begin : send_side
		panel_cmd_t c;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			send_idle <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_idle != 0) begin
				in_valid  <= 1'b0;
				send_idle <= send_idle - 1;
			end else if (cmds_to_send.size() != 0) begin
				c = cmds_to_send.pop_front();
				kind      <= c.kind;
				target    <= c.target;
				value     <= c.value;
				in_valid  <= 1'b1;
				send_idle <= draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Ready drops for a drawn number of cycles after each result transfer.
	always @(posedge clk or negedge arst_n) begin : recv_side
		int stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_idle <= 0;
		end else if (out_valid && out_ready) begin
			stall = draw_wait();
			if (stall != 0) begin
				out_ready <= 1'b0;
				recv_idle <= stall - 1;
			end
		end else if (recv_idle != 0) begin
			recv_idle <= recv_idle - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	task automatic queue_cmd(logic [KIND_W-1:0] k, logic [TARGET_W-1:0] t,
			logic [VALUE_W-1:0] v);
		cmds_to_send.push_back('{kind: k, target: t, value: v});
	endtask

	// Blink periods: mostly short so that toggles are seen, sometimes steady,
	// sometimes anywhere in the 16-bit range.
	function automatic logic [VALUE_W-1:0] draw_period();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			return '0;
		if (roll < 80)
			return VALUE_W'($urandom_range(1, 20));
		return VALUE_W'($urandom_range(0, 65535));
	endfunction

	task automatic queue_random_cmd(int tick_pct);
		panel_cmd_t c;
		int roll;
		c.kind   = KIND_TICK;
		c.target = TARGET_W'($urandom_range(0, 3));
		c.value  = VALUE_W'($urandom_range(0, 65535));
		// Bar writes mostly hit a real bar. The rest go to indexes past the last bar.
		if ($urandom_range(0, 99) >= tick_pct) begin
			roll = $urandom_range(0, 99);
			if (roll < 25) begin
				c.kind = KIND_SET_LED;
				if ($urandom_range(0, 1))
					c.value = VALUE_W'($urandom_range(0, 1));
			end else if (roll < 45) begin
				c.kind  = KIND_LED_BLINK;
				c.value = draw_period();
			end else if (roll < 70) begin
				c.kind   = KIND_BAR_LEVEL;
				c.target = TARGET_W'(($urandom_range(0, 7) == 0) ? $urandom_range(NUM_BARS, 3)
					: $urandom_range(0, NUM_BARS - 1));
				if ($urandom_range(0, 3) != 0)
					c.value = VALUE_W'($urandom_range(0, 7));
			end else if (roll < 92) begin
				c.kind   = KIND_BAR_BLINK;
				c.target = TARGET_W'(($urandom_range(0, 7) == 0) ? $urandom_range(NUM_BARS, 3)
					: $urandom_range(0, NUM_BARS - 1));
				c.value  = draw_period();
			end else begin
				c.kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
			end
		end
		cmds_to_send.push_back(c);
	endtask

	// Wait until every command has gone out and every picture has come back.
	task automatic drain();
		while (cmds_to_send.size() != 0 || in_valid || views_due.size() != 0)
			@(negedge clk);
	endtask

	// Register writes happen only with the block idle. The predictor picks
	// the new value up at the write transfer.
	task automatic write_scan_gap(logic [SCAN_W-1:0] gap);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= gap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// One phase: write the scan interval, pick the idle mix and run random
	// commands. With pause_midway set, the sender stops halfway until every
	// outstanding picture has arrived, then sends the rest.
	task automatic run_phase(logic [SCAN_W-1:0] gap, int n, int tick_pct, int idle,
			bit pause_midway);
		int i;
		write_scan_gap(gap);
		idle_pct = idle;
		for (i = 0; i < n; i++) begin
			if (pause_midway && i == n / 2)
				drain();
			queue_random_cmd(tick_pct);
		end
		drain();
		repeat (4) @(posedge clk);
	endtask

	initial begin
		panel_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset scan interval of 2 ms. Ticks carry junk
		// in target and value, which the block must ignore.
		idle_pct = 0;
		queue_cmd(KIND_TICK, 2'd3, 16'hFFFF);
		queue_cmd(KIND_TICK, 2'd0, 16'h0000);
		queue_cmd(KIND_TICK, 2'd1, 16'h5A5A);	// first scan, bars at blank position
		queue_cmd(KIND_SET_LED, 2'd0, 16'd1);
		queue_cmd(KIND_SET_LED, 2'd3, 16'hFFFF);
		queue_cmd(KIND_SET_LED, 2'd1, 16'd0);
		queue_cmd(KIND_SET_LED, 2'd2, 16'h8000);	// any nonzero value turns the LED on
		queue_cmd(KIND_LED_BLINK, 2'd2, 16'd1);
		queue_cmd(KIND_LED_BLINK, 2'd1, 16'hFFFF);
		queue_cmd(KIND_BAR_LEVEL, 2'd0, 16'd3);
		queue_cmd(KIND_BAR_LEVEL, 2'd1, 16'hFFFF);	// clamps to the top level
		queue_cmd(KIND_BAR_LEVEL, 2'd2, 16'd5);	// no such bar
		queue_cmd(KIND_BAR_BLINK, 2'd1, 16'd2);
		queue_cmd(KIND_BAR_BLINK, 2'd3, 16'd7);	// no such bar
		queue_cmd(KIND_SPARE_FIRST, 2'd0, 16'hFFFF);
		queue_cmd(KIND_SPARE_FIRST + 3'd1, 2'd1, 16'd1);
		queue_cmd(KIND_SPARE_LAST, 2'd2, 16'h00FF);
		queue_cmd(KIND_TICK, 2'd0, 16'd0);
		queue_cmd(KIND_TICK, 2'd0, 16'd0);
		queue_cmd(KIND_TICK, 2'd0, 16'd0);
		queue_cmd(KIND_BAR_LEVEL, 2'd0, 16'd0);	// level 0 still shows position 1 once
		queue_cmd(KIND_TICK, 2'd0, 16'd0);
		queue_cmd(KIND_TICK, 2'd0, 16'd0);
		queue_cmd(KIND_TICK, 2'd0, 16'd0);
		queue_cmd(KIND_TICK, 2'd0, 16'd0);
		drain();
		repeat (4) @(posedge clk);

		// Random phases over the interval range, both extremes included.
		run_phase(8'd0,   300, 60, 0,  1'b0);
		run_phase(8'd1,   250, 60, 40, 1'b1);
		run_phase(8'd255, 450, 90, 25, 1'b0);
		run_phase(8'd2,   250, 55, 80, 1'b0);
		run_phase(8'($urandom_range(3, 16)), 300, 60, 50, 1'b0);
		run_phase(8'd0,   250, 50, 15, 1'b1);

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### filelist.f
hdl/bclp_pkg.sv
hdl/blinking_charlieplex_led_panel_unit.sv
tb/blinking_charlieplex_led_panel_unit_tb.sv
